// ----- sv/protobuf_wire_field_scanner_top_assert.svh -----
// assertion macros for the protobuf wire field scanner
// used by the top level only, needs no package
`ifndef PROTOBUF_WIRE_FIELD_SCANNER_TOP_ASSERT_SVH
`define PROTOBUF_WIRE_FIELD_SCANNER_TOP_ASSERT_SVH

// same-cycle implication, checked while out of reset
`define PWFS_ASSERT_IMPLY(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pwfs assertion failed");

// next-cycle implication, checked while out of reset
`define PWFS_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pwfs assertion failed");

`endif

// ----- sv/pwfs_pkg.sv -----
// shared types and constants for the protobuf wire field scanner
// no dependencies
package pwfs_pkg;

    // result kinds
    typedef enum logic [2:0] {
        KIND_VARINT  = 3'd0,
        KIND_FIXED64 = 3'd1,
        KIND_LENGTH  = 3'd2,
        KIND_PAYLOAD = 3'd3,
        KIND_FIXED32 = 3'd4,
        KIND_ERROR   = 3'd5
    } kind_t;

    // error codes
    typedef enum logic [2:0] {
        ERR_NONE        = 3'd0,
        ERR_TRUNC_VARINT = 3'd1,
        ERR_TOO_LONG    = 3'd2,
        ERR_BAD_WIRE    = 3'd3,
        ERR_TRUNC_FIELD = 3'd4
    } err_t;

    // wire types that are decoded
    localparam logic [2:0] WT_VARINT  = 3'd0;
    localparam logic [2:0] WT_FIXED64 = 3'd1;
    localparam logic [2:0] WT_LENGTH  = 3'd2;
    localparam logic [2:0] WT_FIXED32 = 3'd5;

    // varint and fixed field stepping
    localparam int VARINT_STEP      = 7;
    localparam int VARINT_MAX_SHIFT = 70;
    localparam int BYTE_STEP        = 8;
    localparam int FIXED64_BYTES    = 8;
    localparam int FIXED32_BYTES    = 4;

    // output tdata layout
    localparam int FN_LSB      = 0;
    localparam int WT_LSB      = 32;
    localparam int VAL_LSB     = 35;
    localparam int ERR_LSB     = 99;
    localparam int OUT_TDATA_W = 104;

    // one result item
    typedef struct packed {
        kind_t       kind;
        logic [31:0] field_number;
        logic [2:0]  wire_type;
        logic [63:0] value;
        err_t        error_code;
        logic        buffer_end;
    } res_t;

endpackage

// ----- sv/pwfs_core.sv -----
// decode state and per-byte next-state logic of the field scanner
// depends on pwfs_pkg
module pwfs_core
    import pwfs_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       accept,
    input  logic [7:0] data_byte,
    input  logic       last_byte,
    output logic       res_valid,
    output res_t       res
);

    typedef enum logic [2:0] {
        PH_KEY,
        PH_VARINT,
        PH_FIXED,
        PH_LENGTH,
        PH_PAYLOAD,
        PH_ERROR
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [63:0] acc_reg, acc_next;
    logic [6:0]  shift_reg, shift_next;
    logic [31:0] fn_reg, fn_next;
    logic [2:0]  wt_reg, wt_next;
    logic [63:0] remain_reg, remain_next;

    logic [6:0]  vshift;
    logic [6:0]  fshift;
    logic [63:0] vacc;
    logic [63:0] facc;
    logic [63:0] rem_dec;
    logic        cont;
    logic        too_long;
    logic [31:0] key_fn;
    logic [2:0]  key_wt;

    function automatic res_t make_err(err_t code, logic [31:0] fn, logic [2:0] wt,
                                      logic last);
        res_t r;
        r.kind         = KIND_ERROR;
        r.field_number = fn;
        r.wire_type    = wt;
        r.value        = '0;
        r.error_code   = code;
        r.buffer_end   = last;
        return r;
    endfunction

    function automatic res_t make_ok(kind_t k, logic [31:0] fn, logic [2:0] wt,
                                     logic [63:0] val, logic last);
        res_t r;
        r.kind         = k;
        r.field_number = fn;
        r.wire_type    = wt;
        r.value        = val;
        r.error_code   = ERR_NONE;
        r.buffer_end   = last;
        return r;
    endfunction

    // shared datapath terms
    always_comb
    begin
        vshift   = shift_reg + 7'(VARINT_STEP);
        fshift   = shift_reg + 7'(BYTE_STEP);
        vacc     = acc_reg | (shift_reg[6] ? 64'd0
                                           : ({57'd0, data_byte[6:0]} << shift_reg[5:0]));
        facc     = acc_reg | (shift_reg[6] ? 64'd0
                                           : ({56'd0, data_byte} << shift_reg[5:0]));
        rem_dec  = (remain_reg != 64'd0) ? remain_reg - 64'd1 : remain_reg;
        cont     = data_byte[7];
        too_long = cont && (vshift > 7'(VARINT_MAX_SHIFT));
        key_fn   = vacc[34:3];
        key_wt   = vacc[2:0];
    end

    // next state and result for one byte
    always_comb
    begin
        phase_next  = phase_reg;
        acc_next    = acc_reg;
        shift_next  = shift_reg;
        fn_next     = fn_reg;
        wt_next     = wt_reg;
        remain_next = remain_reg;
        res_valid   = 1'b0;
        res         = make_ok(KIND_VARINT, fn_reg, wt_reg, 64'd0, last_byte);

        case (phase_reg)
            PH_VARINT, PH_LENGTH:
            begin
                if (too_long) begin
                    res_valid  = 1'b1;
                    res        = make_err(ERR_TOO_LONG, fn_reg, wt_reg, last_byte);
                    phase_next = PH_ERROR;
                end else if (cont) begin
                    if (last_byte) begin
                        res_valid  = 1'b1;
                        res        = make_err(ERR_TRUNC_VARINT, fn_reg, wt_reg, last_byte);
                        phase_next = PH_ERROR;
                    end
                end else if (phase_reg == PH_VARINT) begin
                    res_valid  = 1'b1;
                    res        = make_ok(KIND_VARINT, fn_reg, wt_reg, vacc, last_byte);
                    phase_next = PH_KEY;
                end else if (vacc == 64'd0) begin
                    res_valid  = 1'b1;
                    res        = make_ok(KIND_LENGTH, fn_reg, wt_reg, 64'd0, last_byte);
                    phase_next = PH_KEY;
                end else if (last_byte) begin
                    res_valid  = 1'b1;
                    res        = make_err(ERR_TRUNC_FIELD, fn_reg, wt_reg, last_byte);
                    phase_next = PH_ERROR;
                end else begin
                    res_valid   = 1'b1;
                    res         = make_ok(KIND_LENGTH, fn_reg, wt_reg, vacc, last_byte);
                    remain_next = vacc;
                    phase_next  = PH_PAYLOAD;
                end
                // keep accumulating only while the varint continues
                acc_next   = (cont && !too_long) ? vacc : 64'd0;
                shift_next = (cont && !too_long) ? vshift : 7'd0;
            end
            PH_FIXED:
            begin
                remain_next = rem_dec;
                if (rem_dec == 64'd0) begin
                    res_valid  = 1'b1;
                    res        = make_ok(kind_t'((wt_reg == WT_FIXED64) ? KIND_FIXED64
                                                                        : KIND_FIXED32),
                                         fn_reg, wt_reg, facc, last_byte);
                    phase_next = PH_KEY;
                    acc_next   = 64'd0;
                    shift_next = 7'd0;
                end else begin
                    acc_next   = facc;
                    shift_next = fshift;
                    if (last_byte) begin
                        res_valid  = 1'b1;
                        res        = make_err(ERR_TRUNC_FIELD, fn_reg, wt_reg, last_byte);
                        phase_next = PH_ERROR;
                    end
                end
            end
            PH_PAYLOAD:
            begin
                remain_next = rem_dec;
                res_valid   = 1'b1;
                if (rem_dec == 64'd0) begin
                    res        = make_ok(KIND_PAYLOAD, fn_reg, wt_reg, {56'd0, data_byte},
                                         last_byte);
                    phase_next = PH_KEY;
                end else if (last_byte) begin
                    res        = make_err(ERR_TRUNC_FIELD, fn_reg, wt_reg, last_byte);
                    phase_next = PH_ERROR;
                end else begin
                    res = make_ok(KIND_PAYLOAD, fn_reg, wt_reg, {56'd0, data_byte}, last_byte);
                end
            end
            PH_KEY:
            begin
                if (too_long) begin
                    res_valid  = 1'b1;
                    res        = make_err(ERR_TOO_LONG, 32'd0, 3'd0, last_byte);
                    phase_next = PH_ERROR;
                end else if (cont) begin
                    acc_next   = vacc;
                    shift_next = vshift;
                    if (last_byte) begin
                        res_valid  = 1'b1;
                        res        = make_err(ERR_TRUNC_VARINT, 32'd0, 3'd0, last_byte);
                        phase_next = PH_ERROR;
                    end
                end else begin
                    // key complete: split and pick the value phase
                    fn_next    = key_fn;
                    wt_next    = key_wt;
                    acc_next   = 64'd0;
                    shift_next = 7'd0;
                    case (key_wt)
                        WT_VARINT:  phase_next = PH_VARINT;
                        WT_LENGTH:  phase_next = PH_LENGTH;
                        WT_FIXED64:
                        begin
                            phase_next  = PH_FIXED;
                            remain_next = 64'(FIXED64_BYTES);
                        end
                        WT_FIXED32:
                        begin
                            phase_next  = PH_FIXED;
                            remain_next = 64'(FIXED32_BYTES);
                        end
                        default:
                        begin
                            res_valid  = 1'b1;
                            res        = make_err(ERR_BAD_WIRE, key_fn, key_wt, last_byte);
                            phase_next = PH_ERROR;
                        end
                    endcase
                    // key on the final byte leaves the value missing
                    if (!res_valid && last_byte) begin
                        res_valid  = 1'b1;
                        res        = make_err(err_t'((key_wt == WT_VARINT ||
                                                      key_wt == WT_LENGTH)
                                                     ? ERR_TRUNC_VARINT : ERR_TRUNC_FIELD),
                                              key_fn, key_wt, last_byte);
                        phase_next = PH_ERROR;
                    end
                end
            end
            default:
            begin
                // error phase: bytes dropped until the buffer ends
                res_valid = 1'b0;
            end
        endcase

        // final byte always returns to the reset state
        if (last_byte) begin
            phase_next  = PH_KEY;
            acc_next    = 64'd0;
            shift_next  = 7'd0;
            fn_next     = 32'd0;
            wt_next     = 3'd0;
            remain_next = 64'd0;
        end
    end

    // decode state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            phase_reg  <= PH_KEY;
            acc_reg    <= '0;
            shift_reg  <= '0;
            fn_reg     <= '0;
            wt_reg     <= '0;
            remain_reg <= '0;
        end else if (accept) begin
            phase_reg  <= phase_next;
            acc_reg    <= acc_next;
            shift_reg  <= shift_next;
            fn_reg     <= fn_next;
            wt_reg     <= wt_next;
            remain_reg <= remain_next;
        end
    end

endmodule

// ----- sv/pwfs_out_reg.sv -----
// result register between the decoder and the output stream
// depends on pwfs_pkg
module pwfs_out_reg
    import pwfs_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic load,
    input  logic res_valid,
    input  res_t res,
    input  logic take,
    output logic ready,
    output logic valid,
    output res_t data
);

    logic valid_reg;
    res_t data_reg;

    // a new byte may enter when the slot is empty or drains this cycle
    assign ready = !valid_reg || take;
    assign valid = valid_reg;
    assign data  = data_reg;

    // valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            valid_reg <= 1'b0;
        end else if (load) begin
            valid_reg <= res_valid;
        end else if (take) begin
            valid_reg <= 1'b0;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (load && res_valid) begin
            data_reg <= res;
        end
    end

endmodule

// ----- sv/protobuf_wire_field_scanner_top.sv -----
// Protobuf wire field scanner: takes one byte of an encoded buffer per transfer,
// tlast on the final byte, and emits at most one result per byte: a varint,
// fixed64 or fixed32 field, a length header, a payload byte, or an error. A
// byte is decoded in the cycle it is accepted and its result sits in the output
// register from the next cycle on; a new byte is taken every cycle as long as the
// output register is empty or being drained, so throughput is one byte per
// clock, set by the single decode step between the state and result registers.
// After an error bytes produce nothing until the final byte, which always
// returns the scanner to its reset state. No start-up sequence after reset.
// depends on pwfs_pkg, pwfs_core, pwfs_out_reg and the assertion header
`include "protobuf_wire_field_scanner_top_assert.svh"

module protobuf_wire_field_scanner_top
    import pwfs_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [7:0]             s_tdata,   // data_byte [7:0]
    input  logic                   s_tlast,   // last_byte
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // field_number [31:0], wire_type [34:32], value [98:35], error_code [101:99], zero pad
    output logic [OUT_TDATA_W-1:0] m_tdata,
    output logic [2:0]             m_tuser,   // kind [2:0]
    output logic                   m_tlast    // buffer_end
);

    logic accept;
    logic res_valid;
    res_t res;
    res_t res_q;

    assign accept = s_tvalid && s_tready;

    // per-byte decoder with its state
    pwfs_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .data_byte (s_tdata),
        .last_byte (s_tlast),
        .res_valid (res_valid),
        .res       (res)
    );

    // output register
    pwfs_out_reg u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (accept),
        .res_valid (res_valid),
        .res       (res),
        .take      (m_tready),
        .ready     (s_tready),
        .valid     (m_tvalid),
        .data      (res_q)
    );

    // pack the output transfer
    assign m_tdata = {2'b00, res_q.error_code, res_q.value, res_q.wire_type,
                      res_q.field_number};
    assign m_tuser = res_q.kind;
    assign m_tlast = res_q.buffer_end;

    // error results carry a code and a zero value, others carry no code
    `PWFS_ASSERT_IMPLY(a_err_code, clk, rst_n, m_tvalid,
        (m_tuser == KIND_ERROR) == (m_tdata[ERR_LSB+2:ERR_LSB] != ERR_NONE))
    `PWFS_ASSERT_IMPLY(a_err_value, clk, rst_n, m_tvalid && m_tuser == KIND_ERROR,
        m_tdata[VAL_LSB+63:VAL_LSB] == 64'd0)
    // a payload result holds a single byte
    `PWFS_ASSERT_IMPLY(a_payload_byte, clk, rst_n, m_tvalid && m_tuser == KIND_PAYLOAD,
        m_tdata[VAL_LSB+63:VAL_LSB+8] == 56'd0)
    // a result right after the final byte belongs to that byte
    `PWFS_ASSERT_NEXT(a_end_tag, clk, rst_n, s_tvalid && s_tready && s_tlast,
        !m_tvalid || m_tlast)

endmodule

// ----- tb/sv/protobuf_wire_field_scanner_top_tb.sv -----
// self-checking testbench for the protobuf wire field scanner top level
// streams encoded buffers in, decodes them in a local model and checks every result
// depends on pwfs_pkg and protobuf_wire_field_scanner_top
module protobuf_wire_field_scanner_top_tb;
    import pwfs_pkg::*;

    localparam int STALL_LIMIT  = 4000;
    localparam int DRAIN_CYCLES = 16;
    localparam int HOLD_CYCLES  = 300;

    // wire type reported while no key has been decoded yet
    localparam logic [2:0] WT_NONE = 3'd0;

    typedef enum logic [2:0] {
        ST_KEY,
        ST_VARINT,
        ST_FIXED,
        ST_LENGTH,
        ST_PAYLOAD,
        ST_SKIP
    } scan_state_t;

    typedef enum logic [1:0] {
        VAR_MORE,
        VAR_DONE,
        VAR_LONG
    } var_step_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [7:0]             s_tdata = 8'd0;
    logic                   s_tlast = 1'b0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic [2:0]             m_tuser;
    logic                   m_tlast;

    // idling knobs (idle and stall in percent of cycles) and run counters
    int idle_pct = 0;
    int stall_pct = 0;
    int hold_cycles = 0;
    int quiet_cycles = 0;
    int mismatch_count = 0;

    // decoder model state
    scan_state_t scan_state = ST_KEY;
    logic [63:0] scan_acc = '0;
    int          scan_shift = 0;
    logic [31:0] scan_fn = '0;
    logic [2:0]  scan_wt = '0;
    logic [63:0] scan_left = '0;

    res_t pending_fields[$];

    protobuf_wire_field_scanner_top DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always #1 clk = ~clk;

    // ---------------------------------------------------------------
    // decoder model
    // ---------------------------------------------------------------

    function automatic void clear_scan();
        scan_state = ST_KEY;
        scan_acc   = '0;
        scan_shift = 0;
        scan_fn    = '0;
        scan_wt    = '0;
        scan_left  = '0;
    endfunction

    function automatic void post_result(kind_t k, logic [31:0] fn, logic [2:0] wt,
                                        logic [63:0] val, err_t code, logic last);
        res_t r;
        r.kind         = k;
        r.field_number = fn;
        r.wire_type    = wt;
        r.value        = val;
        r.error_code   = code;
        r.buffer_end   = last;
        pending_fields.insert(pending_fields.size(), r);
    endfunction

    function automatic void raise_error(err_t code, logic [31:0] fn, logic [2:0] wt,
                                        logic last);
        post_result(KIND_ERROR, fn, wt, 64'd0, code, last);
        scan_state = ST_SKIP;
    endfunction

    // fold one varint byte into the accumulator, bits past 64 dropped
    function automatic var_step_t absorb_varint(logic [7:0] b);
        if (scan_shift < 64)
            scan_acc |= {57'd0, b[6:0]} << scan_shift;
        if (!b[7])
            return VAR_DONE;
        scan_shift += VARINT_STEP;
        if (scan_shift > VARINT_MAX_SHIFT)
            return VAR_LONG;
        return VAR_MORE;
    endfunction

    function automatic void decode_byte(logic [7:0] b, logic last);
        var_step_t step;
        kind_t     fixed_kind;
        err_t      code;
        // after an error only the final byte matters
        if (scan_state == ST_SKIP)
        begin
            if (last)
                clear_scan();
            return;
        end
        case (scan_state)
            ST_VARINT, ST_LENGTH:
            begin
                step = absorb_varint(b);
                if (step == VAR_LONG)
                    raise_error(ERR_TOO_LONG, scan_fn, scan_wt, last);
                else if (step == VAR_MORE)
                begin
                    if (last)
                        raise_error(ERR_TRUNC_VARINT, scan_fn, scan_wt, last);
                end
                else if (scan_state == ST_VARINT)
                begin
                    post_result(KIND_VARINT, scan_fn, scan_wt, scan_acc, ERR_NONE, last);
                    scan_state = ST_KEY;
                end
                else if (scan_acc == 64'd0)
                begin
                    post_result(KIND_LENGTH, scan_fn, scan_wt, 64'd0, ERR_NONE, last);
                    scan_state = ST_KEY;
                end
                else if (last)
                    raise_error(ERR_TRUNC_FIELD, scan_fn, scan_wt, last);
                else
                begin
                    post_result(KIND_LENGTH, scan_fn, scan_wt, scan_acc, ERR_NONE, last);
                    scan_left  = scan_acc;
                    scan_state = ST_PAYLOAD;
                end
                if (step != VAR_MORE)
                begin
                    scan_acc   = '0;
                    scan_shift = 0;
                end
            end
            ST_FIXED:
            begin
                // little-endian assembly
                if (scan_shift < 64)
                    scan_acc |= {56'd0, b} << scan_shift;
                scan_shift += BYTE_STEP;
                if (scan_left != 0)
                    scan_left--;
                if (scan_left == 0)
                begin
                    if (scan_wt == WT_FIXED64)
                        fixed_kind = KIND_FIXED64;
                    else
                        fixed_kind = KIND_FIXED32;
                    post_result(fixed_kind, scan_fn, scan_wt, scan_acc, ERR_NONE, last);
                    scan_state = ST_KEY;
                    scan_acc   = '0;
                    scan_shift = 0;
                end
                else if (last)
                    raise_error(ERR_TRUNC_FIELD, scan_fn, scan_wt, last);
            end
            ST_PAYLOAD:
            begin
                if (scan_left != 0)
                    scan_left--;
                if (scan_left == 0)
                begin
                    post_result(KIND_PAYLOAD, scan_fn, scan_wt, {56'd0, b}, ERR_NONE, last);
                    scan_state = ST_KEY;
                end
                else if (last)
                    raise_error(ERR_TRUNC_FIELD, scan_fn, scan_wt, last);
                else
                    post_result(KIND_PAYLOAD, scan_fn, scan_wt, {56'd0, b}, ERR_NONE, last);
            end
            default:
            begin
                step = absorb_varint(b);
                if (step == VAR_LONG)
                    raise_error(ERR_TOO_LONG, 32'd0, WT_NONE, last);
                else if (step == VAR_MORE)
                begin
                    if (last)
                        raise_error(ERR_TRUNC_VARINT, 32'd0, WT_NONE, last);
                end
                else
                begin
                    // key complete: split into field number and wire type
                    scan_fn    = scan_acc[34:3];
                    scan_wt    = scan_acc[2:0];
                    scan_acc   = '0;
                    scan_shift = 0;
                    case (scan_wt)
                        WT_VARINT:
                            scan_state = ST_VARINT;
                        WT_FIXED64:
                        begin
                            scan_state = ST_FIXED;
                            scan_left  = 64'(FIXED64_BYTES);
                        end
                        WT_LENGTH:
                            scan_state = ST_LENGTH;
                        WT_FIXED32:
                        begin
                            scan_state = ST_FIXED;
                            scan_left  = 64'(FIXED32_BYTES);
                        end
                        default:
                            raise_error(ERR_BAD_WIRE, scan_fn, scan_wt, last);
                    endcase
                    // key on the final byte leaves the value missing
                    if (scan_state != ST_SKIP && last)
                    begin
                        if (scan_wt == WT_VARINT || scan_wt == WT_LENGTH)
                            code = ERR_TRUNC_VARINT;
                        else
                            code = ERR_TRUNC_FIELD;
                        raise_error(code, scan_fn, scan_wt, last);
                    end
                end
            end
        endcase
        if (last)
            clear_scan();
    endfunction

    // ---------------------------------------------------------------
    // stimulus helpers
    // ---------------------------------------------------------------

    task automatic send_byte(input logic [7:0] b, input logic last);
        @(negedge clk);
        while ($urandom_range(0, 99) < idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= last;
        do
            @(posedge clk);
        while (!s_tready);
        decode_byte(b, last);
    endtask

    task automatic send_stream(input logic [7:0] q[$]);
        foreach (q[i])
            send_byte(q[i], i == q.size() - 1);
    endtask

    function automatic logic [63:0] pick_value();
        case ($urandom_range(0, 5))
            0: return 64'd0;
            1: return 64'($urandom_range(0, 127));
            2: return '1;
            3: return {$urandom, $urandom};
            4: return {$urandom, $urandom} >> $urandom_range(0, 63);
            default: return 64'd1 << $urandom_range(0, 63);
        endcase
    endfunction

    function automatic logic [31:0] pick_field_number();
        case ($urandom_range(0, 4))
            0: return 32'($urandom_range(1, 15));
            1: return 32'd0;
            2: return '1;
            default: return $urandom;
        endcase
    endfunction

    // shortest encoding, sometimes padded out to as many as 11 bytes
    function automatic int varint_len(input logic [63:0] v);
        int n;
        n = 1;
        while (n < 10 && (v >> (VARINT_STEP * n)) != 0)
            n++;
        if ($urandom_range(0, 3) == 0)
            n = $urandom_range(n, 11);
        return n;
    endfunction

    function automatic void put_varint(ref logic [7:0] q[$], input logic [63:0] v,
                                       input int nbytes);
        logic [7:0] b;
        for (int i = 0; i < nbytes; i++)
        begin
            b = {1'b0, 7'(v >> (VARINT_STEP * i))};
            // bits that land past bit 63 are junk the decoder drops
            if (i == 9)
                b[6:1] = 6'($urandom);
            else if (i == 10)
                b[6:0] = 7'($urandom);
            b[7] = (i != nbytes - 1);
            q.insert(q.size(), b);
        end
    endfunction

    function automatic void put_key(ref logic [7:0] q[$], input logic [31:0] fn,
                                    input logic [2:0] wt);
        logic [63:0] key;
        key = {29'd0, fn, wt};
        if ($urandom_range(0, 7) == 0)
            key[63:35] = 29'($urandom);
        put_varint(q, key, varint_len(key));
    endfunction

    function automatic void put_le(ref logic [7:0] q[$], input logic [63:0] v,
                                   input int nbytes);
        for (int i = 0; i < nbytes; i++)
            q.insert(q.size(), v[8 * i +: 8]);
    endfunction

    // one buffer: mostly well-formed fields, some noise and broken endings
    task automatic build_stream(ref logic [7:0] q[$]);
        int          nfields;
        int          roll;
        int          len;
        logic [2:0]  wt;
        logic [63:0] v;
        q.delete();
        if ($urandom_range(0, 99) < 8)
        begin
            repeat ($urandom_range(1, 10))
                q.insert(q.size(), 8'($urandom));
            return;
        end
        nfields = $urandom_range(1, 5);
        for (int f = 0; f < nfields; f++)
        begin
            roll = $urandom_range(0, 11);
            if (roll <= 2)
            begin
                v = pick_value();
                put_key(q, pick_field_number(), WT_VARINT);
                put_varint(q, v, varint_len(v));
            end
            else if (roll <= 4)
            begin
                put_key(q, pick_field_number(), WT_FIXED64);
                put_le(q, pick_value(), FIXED64_BYTES);
            end
            else if (roll <= 6)
            begin
                put_key(q, pick_field_number(), WT_FIXED32);
                put_le(q, pick_value(), FIXED32_BYTES);
            end
            else if (roll <= 9)
            begin
                if ($urandom_range(0, 9) == 0)
                    len = $urandom_range(7, 40);
                else
                    len = $urandom_range(0, 6);
                put_key(q, pick_field_number(), WT_LENGTH);
                put_varint(q, 64'(len), varint_len(64'(len)));
                repeat (len)
                    q.insert(q.size(), 8'($urandom));
            end
            else if (roll == 10)
            begin
                // unsupported wire type, trailing bytes get skipped
                do
                    wt = 3'($urandom);
                while (wt == WT_VARINT || wt == WT_FIXED64 || wt == WT_LENGTH ||
                       wt == WT_FIXED32);
                put_key(q, pick_field_number(), wt);
                repeat ($urandom_range(0, 3))
                    q.insert(q.size(), 8'($urandom));
                break;
            end
            else
            begin
                // length longer than what is left of the buffer
                len = $urandom_range(0, 3);
                v = pick_value();
                if (v <= 64'(len))
                    v = 64'(len + 1);
                put_key(q, pick_field_number(), WT_LENGTH);
                put_varint(q, v, varint_len(v));
                repeat (len)
                    q.insert(q.size(), 8'($urandom));
                break;
            end
        end
        roll = $urandom_range(0, 99);
        if (roll < 15 && q.size() > 1)
            q = q[0 : $urandom_range(0, q.size() - 2)];
        else if (roll < 22)
            repeat (11)
                q.insert(q.size(), 8'h80 | 8'($urandom));
    endtask

    task automatic log_mismatch(input string what);
        $display("%0t mismatch: %s", $time, what);
        mismatch_count++;
    endtask

    // ---------------------------------------------------------------
    // tests
    // ---------------------------------------------------------------

    task automatic test_directed();
        logic [7:0] stream[$];
        idle_pct  = 0;
        stall_pct = 0;
        // varint 150, length one, payload byte on the final byte
        stream = {8'h08, 8'h96, 8'h01, 8'h12, 8'h01, 8'hAA};
        send_stream(stream);
        // zero length header on the final byte
        stream = {8'h12, 8'h00};
        send_stream(stream);
        // bad wire type, rest of the buffer skipped
        stream = {8'h0B, 8'h00, 8'hFF};
        send_stream(stream);
        // fixed64 key alone on the final byte
        stream = {8'h09};
        send_stream(stream);
        // fixed32 cut short
        stream = {8'h0D, 8'h01, 8'h02};
        send_stream(stream);
        // key varint cut short
        stream = {8'h80};
        send_stream(stream);
        // key varint over eleven bytes
        stream.delete();
        repeat (11)
            stream.insert(stream.size(), 8'hFF);
        send_stream(stream);
    endtask

    task automatic test_random_streams(input int idle, input int stall, input int n_bytes);
        logic [7:0] stream[$];
        int         sent;
        idle_pct  = idle;
        stall_pct = stall;
        sent = 0;
        while (sent < n_bytes)
        begin
            build_stream(stream);
            send_stream(stream);
            sent += stream.size();
        end
    endtask

    // receiver holds off while bytes keep coming, so the input stalls
    task automatic test_backpressure();
        idle_pct    = 0;
        stall_pct   = 0;
        hold_cycles = HOLD_CYCLES;
        test_random_streams(0, 0, 40);
    endtask

    // ---------------------------------------------------------------
    // receiver side
    // ---------------------------------------------------------------

    always @(negedge clk)
    begin
        if (hold_cycles != 0)
        begin
            hold_cycles <= hold_cycles - 1;
            m_tready    <= 1'b0;
        end
        else
            m_tready <= ($urandom_range(0, 99) >= stall_pct);
    end

    // compare each result transfer with the oldest expected field
    always @(posedge clk)
    begin
        res_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_fields.size() == 0)
                log_mismatch("result with nothing expected");
            else
            begin
                want = pending_fields.pop_front();
                if (m_tuser !== want.kind)
                    log_mismatch($sformatf("kind %0d, want %0d", m_tuser, want.kind));
                if (m_tdata[FN_LSB +: 32] !== want.field_number)
                    log_mismatch($sformatf("field number %0h, want %0h",
                                           m_tdata[FN_LSB +: 32], want.field_number));
                if (m_tdata[WT_LSB +: 3] !== want.wire_type)
                    log_mismatch($sformatf("wire type %0d, want %0d",
                                           m_tdata[WT_LSB +: 3], want.wire_type));
                if (m_tdata[VAL_LSB +: 64] !== want.value)
                    log_mismatch($sformatf("value %0h, want %0h",
                                           m_tdata[VAL_LSB +: 64], want.value));
                if (m_tdata[ERR_LSB +: 3] !== want.error_code)
                    log_mismatch($sformatf("error code %0d, want %0d",
                                           m_tdata[ERR_LSB +: 3], want.error_code));
                if (m_tlast !== want.buffer_end)
                    log_mismatch($sformatf("buffer end %0b, want %0b",
                                           m_tlast, want.buffer_end));
            end
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // sequence
    // ---------------------------------------------------------------

    initial
    begin
        clear_scan();
        repeat (3)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_directed();
        test_random_streams(0, 0, 180);
        test_random_streams(84, 0, 180);
        test_random_streams(0, 84, 180);
        test_random_streams(27, 27, 180);
        test_backpressure();

        @(negedge clk);
        s_tvalid <= 1'b0;
        while (pending_fields.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES)
            @(posedge clk);

        if (mismatch_count == 0 && pending_fields.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
